[hdl/key1bf_pkg.sv]
// Shared types, constants and helpers for the KEY1 block cipher core.
package key1bf_pkg;

  localparam int TableWords = 1042;          // P array plus four S-boxes
  localparam int PWords     = 18;
  localparam int SboxBase   = 'h048 / 4;     // first S-box word
  localparam int Rounds     = 16;
  localparam int RegenPairs = TableWords / 2;

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_KEY  = 2'd1,
    OP_ENC  = 2'd2,
    OP_DEC  = 2'd3
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [10:0] index;
    logic [31:0] data;
    logic [31:0] w0;
    logic [31:0] w1;
    logic [31:0] id;
    logic [1:0]  level;
    logic [1:0]  modulo;   // already forced to 1..3
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

  // i mod 3 for the P words
  localparam logic [1:0] Mod3 [PWords] = '{
    2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2,
    2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2
  };

  function automatic logic [31:0] swap_bytes(input logic [31:0] v);
    return {v[7:0], v[15:8], v[23:16], v[31:24]};
  endfunction

endpackage

[hdl/key1bf_front.sv]
// Front end: takes input items, classifies them and forms queue commands.
module key1bf_front import key1bf_pkg::*; (
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  op,
  input  logic [10:0] table_index,
  input  logic [31:0] table_word,
  input  logic [31:0] block_low,
  input  logic [31:0] block_high,
  input  logic [31:0] key_id,
  input  logic [1:0]  key_level,
  input  logic [1:0]  key_modulo,
  input  q_stat_t     q_stat,
  output logic        push,
  output cmd_t        cmd
);

  logic accept;
  logic drop;

  assign in_stall = q_stat.full;
  assign accept   = in_valid && !q_stat.full;

  // loads beyond the table are taken and discarded
  assign drop = (op_t'(op) == OP_LOAD) && (table_index >= 11'(TableWords));
  assign push = accept && !drop;

  always_comb begin
    cmd.op     = op_t'(op);
    cmd.index  = table_index;
    cmd.data   = table_word;
    cmd.w0     = block_low;
    cmd.w1     = block_high;
    cmd.id     = key_id;
    cmd.level  = key_level;
    cmd.modulo = (key_modulo == 2'd0) ? 2'd1 : key_modulo;
  end

endmodule

[hdl/key1bf_queue.sv]
// Two-entry command queue between front and back end.
module key1bf_queue import key1bf_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  cmd_t    push_cmd,
  input  logic    pop,
  output cmd_t    head,
  output q_stat_t q_stat
);

  cmd_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_cmd;
  end

  assign head         = slots[rd_ptr];
  assign q_stat.empty = (count == 2'd0);
  assign q_stat.full  = (count == 2'd2);

endmodule

[hdl/key1bf_back.sv]
// Back end: table memories, round engine, key schedule sequencer, result register.
module key1bf_back import key1bf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        head,
  input  q_stat_t     q_stat,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_low,
  output logic [31:0] out_high
);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_COPY  = 9'b000000010,
    S_KC1   = 9'b000000100,
    S_KC0   = 9'b000001000,
    S_PXOR  = 9'b000010000,
    S_RGE   = 9'b000100000,
    S_RGW0  = 9'b001000000,
    S_RGW1  = 9'b010000000,
    S_CRYPT = 9'b100000000
  } state_t;

  state_t state;

  // tables
  logic [31:0] pristine [TableWords];
  logic [31:0] sbox [4][256];
  logic [31:0] p [PWords];
  logic [31:0] pr_q;
  logic [31:0] sd [4];

  // engine
  logic [31:0] ex, ey, zr;
  logic [4:0]  rc;
  logic        ph;
  logic        dec;
  logic [4:0]  pidx;
  logic [31:0] z, f, r0, r1;
  logic        eng_done;

  // sequencer
  logic [10:0] cnt;
  logic [9:0]  pi;
  logic [1:0]  pass, pass_n;
  logic [1:0]  level, modulo;
  logic [31:0] kc [3];
  logic [31:0] s0, s1;
  logic        slot_free;

  // working table write port
  logic        wr_en;
  logic [10:0] wr_idx;
  logic [31:0] wr_data;
  logic [10:0] wr_off;

  assign pidx     = dec ? (5'd17 - rc) : rc;
  assign z        = p[pidx] ^ ex;
  assign f        = ((sd[0] + sd[1]) ^ sd[2]) + sd[3];
  assign eng_done = (rc == 5'(Rounds));
  assign r0       = ex ^ (dec ? p[1] : p[16]);
  assign r1       = ey ^ (dec ? p[0] : p[17]);
  assign pass_n   = pass + 2'd1;

  assign pop       = (state == S_IDLE) && !q_stat.empty;
  assign slot_free = !out_valid || !out_stall;

  // S-box reads follow the round function input
  always_ff @(posedge clk) begin
    sd[0] <= sbox[0][z[31:24]];
    sd[1] <= sbox[1][z[23:16]];
    sd[2] <= sbox[2][z[15:8]];
    sd[3] <= sbox[3][z[7:0]];
  end

  // pristine table
  always_ff @(posedge clk) begin
    if (pop && head.op == OP_LOAD) pristine[head.index] <= head.data;
    if (cnt < 11'(TableWords)) pr_q <= pristine[cnt];
  end

  // working table write source
  always_comb begin
    wr_en   = 1'b0;
    wr_idx  = cnt - 11'd1;
    wr_data = pr_q;
    unique case (state)
      S_COPY: wr_en = (cnt != 11'd0);
      S_RGW0: begin
        wr_en   = 1'b1;
        wr_idx  = {pi, 1'b0};
        wr_data = s1;
      end
      S_RGW1: begin
        wr_en   = 1'b1;
        wr_idx  = {pi, 1'b1};
        wr_data = s0;
      end
      default: wr_en = 1'b0;
    endcase
  end

  assign wr_off = wr_idx - 11'(SboxBase);

  always_ff @(posedge clk) begin
    if (wr_en && wr_idx >= 11'(SboxBase)) sbox[wr_off[9:8]][wr_off[7:0]] <= wr_data;
  end

  // P array in flops
  always_ff @(posedge clk) begin
    if (state == S_PXOR) begin
      for (int i = 0; i < PWords; i++) begin
        if (modulo == 2'd3)      p[i] <= p[i] ^ swap_bytes(kc[Mod3[i]]);
        else if (modulo == 2'd2) p[i] <= p[i] ^ swap_bytes(kc[{1'b0, i[0]}]);
        else                     p[i] <= p[i] ^ swap_bytes(kc[0]);
      end
    end else if (wr_en && wr_idx < 11'(SboxBase)) begin
      p[wr_idx[4:0]] <= wr_data;
    end
  end

  // sequencer and engine
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      cnt       <= 11'd0;
      rc        <= 5'd0;
      ph        <= 1'b0;
    end else begin
      if (state == S_CRYPT && eng_done && slot_free) out_valid <= 1'b1;
      else if (out_valid && !out_stall)              out_valid <= 1'b0;

      // round steps run in every engine state until done
      if ((state == S_KC1 || state == S_KC0 || state == S_RGE || state == S_CRYPT)
          && !eng_done) begin
        if (!ph) begin
          zr <= z;
          ph <= 1'b1;
        end else begin
          ex <= f ^ ey;
          ey <= zr;
          rc <= rc + 5'd1;
          ph <= 1'b0;
        end
      end

      unique case (state)
        S_IDLE: begin
          if (pop) begin
            unique case (head.op)
              OP_LOAD: state <= S_IDLE;
              OP_KEY: begin
                level  <= head.level;
                modulo <= head.modulo;
                kc[0]  <= head.id;
                kc[1]  <= head.id >> 1;
                kc[2]  <= head.id << 1;
                cnt    <= 11'd0;
                state  <= S_COPY;
              end
              OP_ENC, OP_DEC: begin
                ex    <= head.w1;
                ey    <= head.w0;
                dec   <= (head.op == OP_DEC);
                rc    <= 5'd0;
                ph    <= 1'b0;
                state <= S_CRYPT;
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_COPY: begin
          if (cnt == 11'(TableWords)) begin
            cnt  <= 11'd0;
            pass <= 2'd0;
            if (level == 2'd0) begin
              state <= S_IDLE;
            end else begin
              ex    <= kc[2];
              ey    <= kc[1];
              dec   <= 1'b0;
              rc    <= 5'd0;
              ph    <= 1'b0;
              state <= S_KC1;
            end
          end else begin
            cnt <= cnt + 11'd1;
          end
        end
        S_KC1: begin
          if (eng_done) begin
            kc[1] <= r0;
            kc[2] <= r1;
            ex    <= r0;
            ey    <= kc[0];
            rc    <= 5'd0;
            ph    <= 1'b0;
            state <= S_KC0;
          end
        end
        S_KC0: begin
          if (eng_done) begin
            kc[0] <= r0;
            kc[1] <= r1;
            state <= S_PXOR;
          end
        end
        S_PXOR: begin
          s0    <= 32'd0;
          s1    <= 32'd0;
          pi    <= 10'd0;
          ex    <= 32'd0;
          ey    <= 32'd0;
          rc    <= 5'd0;
          ph    <= 1'b0;
          state <= S_RGE;
        end
        S_RGE: begin
          if (eng_done) begin
            s0    <= r0;
            s1    <= r1;
            state <= S_RGW0;
          end
        end
        S_RGW0: state <= S_RGW1;
        S_RGW1: begin
          rc <= 5'd0;
          ph <= 1'b0;
          if (pi == 10'(RegenPairs - 1)) begin
            pass <= pass_n;
            if (pass_n == level) begin
              state <= S_IDLE;
            end else if (pass_n == 2'd2) begin
              // third pass: keycode words 1 and 2 shifted first
              kc[1] <= kc[1] << 1;
              kc[2] <= kc[2] >> 1;
              ex    <= kc[2] >> 1;
              ey    <= kc[1] << 1;
              state <= S_KC1;
            end else begin
              ex    <= kc[2];
              ey    <= kc[1];
              state <= S_KC1;
            end
          end else begin
            pi    <= pi + 10'd1;
            ex    <= s1;
            ey    <= s0;
            state <= S_RGE;
          end
        end
        S_CRYPT: begin
          if (eng_done && slot_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_CRYPT && eng_done && slot_free) begin
      out_low  <= r0;
      out_high <= r1;
    end
  end

endmodule

[hdl/key1_blowfish_cipher_core.sv]
// Top level of the KEY1 Blowfish-style block cipher core.
// A front end takes items and turns them into commands for a two-entry queue;
// the back end pops one command at a time and carries it out. A load writes one
// word of the pristine table and frees the back end the next cycle; loads at
// index 1042 or above are taken and dropped. Encrypt and decrypt run 16 rounds,
// each a registered S-box read, then a round update; the back end pops the next
// command only after the result of a block has been registered. Key init copies
// the pristine table, then each keycode pass runs 521 chained block encryptions
// with two table writes each. The result sits in an output register, so new
// items keep flowing into the queue, until it is full, while a result waits to
// be taken. Tables have no reset value: load every pristine word before the
// first key init.
module key1_blowfish_cipher_core import key1bf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  op,
  input  logic [10:0] table_index,
  input  logic [31:0] table_word,
  input  logic [31:0] block_low,
  input  logic [31:0] block_high,
  input  logic [31:0] key_id,
  input  logic [1:0]  key_level,
  input  logic [1:0]  key_modulo,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_low,
  output logic [31:0] out_high
);

  q_stat_t q_stat;
  cmd_t    push_cmd;
  cmd_t    head;
  logic    push;
  logic    pop;

  // accept and classify
  key1bf_front u_front (
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .op          (op),
    .table_index (table_index),
    .table_word  (table_word),
    .block_low   (block_low),
    .block_high  (block_high),
    .key_id      (key_id),
    .key_level   (key_level),
    .key_modulo  (key_modulo),
    .q_stat      (q_stat),
    .push        (push),
    .cmd         (push_cmd)
  );

  // decoupling queue
  key1bf_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .q_stat   (q_stat)
  );

  // execution
  key1bf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .q_stat    (q_stat),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_low   (out_low),
    .out_high  (out_high)
  );

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_stat.full) else $error("push into full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_stat.empty) else $error("pop from empty queue");

  a_full_stalls: assert property (@(posedge clk) disable iff (rst)
    q_stat.full |-> in_stall) else $error("item taken while queue full");

endmodule

[tb/sv/tb_key1_blowfish_cipher_core.sv]
// Self-checking testbench for the KEY1 Blowfish-style cipher core.
module tb_key1_blowfish_cipher_core import key1bf_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  op = OP_LOAD;
  logic [10:0] table_index = '0;
  logic [31:0] table_word = '0;
  logic [31:0] block_low = '0;
  logic [31:0] block_high = '0;
  logic [31:0] key_id = '0;
  logic [1:0]  key_level = '0;
  logic [1:0]  key_modulo = 2'd1;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_low;
  logic [31:0] out_high;

  key1_blowfish_cipher_core dut (.*);

  always #10 clk = ~clk;

  // Model copy of both tables; every pristine word is loaded before first use
  bit [31:0] pristine_words [TableWords];
  bit [31:0] cipher_words [TableWords];

  typedef struct {
    bit [31:0] lo;
    bit [31:0] hi;
  } block_t;

  block_t pending_blocks [$];
  int     fail_count = 0;
  bit     quiet_phase = 1'b0;   // no idling on either side once set
  int     key_inits_left = 3;   // caps the costly random key inits
  int     stall_left = 0;       // remaining cycles of the current output stall

  // ---------------------------------------------------------------- predictor
  function automatic bit [31:0] round_mix(bit [31:0] z);
    bit [31:0] x;
    x = cipher_words[SboxBase + z[31:24]];
    x = cipher_words[SboxBase + 256 + z[23:16]] + x;
    x = cipher_words[SboxBase + 512 + z[15:8]] ^ x;
    x = cipher_words[SboxBase + 768 + z[7:0]] + x;
    return x;
  endfunction

  function automatic block_t cipher_block(block_t b, bit decrypt);
    bit [31:0] x, y, z;
    int k;
    x = b.hi;
    y = b.lo;
    for (int r = 0; r < Rounds; r++) begin
      k = decrypt ? 17 - r : r;
      z = cipher_words[k] ^ x;
      x = round_mix(z) ^ y;
      y = z;
    end
    b.lo = x ^ cipher_words[decrypt ? 1 : 16];
    b.hi = y ^ cipher_words[decrypt ? 0 : 17];
    return b;
  endfunction

  function automatic void keycode_pass(ref bit [31:0] kc [3], input int modulo);
    block_t b;
    b = cipher_block('{lo: kc[1], hi: kc[2]}, 1'b0);
    kc[1] = b.lo;
    kc[2] = b.hi;
    b = cipher_block('{lo: kc[0], hi: kc[1]}, 1'b0);
    kc[0] = b.lo;
    kc[1] = b.hi;
    for (int i = 0; i < PWords; i++)
      cipher_words[i] ^= {kc[i % modulo][7:0], kc[i % modulo][15:8],
                          kc[i % modulo][23:16], kc[i % modulo][31:24]};
    b = '{lo: 0, hi: 0};
    for (int i = 0; i + 1 < TableWords; i += 2) begin
      b = cipher_block(b, 1'b0);
      cipher_words[i] = b.hi;
      cipher_words[i + 1] = b.lo;
    end
  endfunction

  function automatic void apply_key(bit [31:0] id, bit [1:0] level, bit [1:0] modulo);
    bit [31:0] kc [3];
    int m;
    m = (modulo == 0) ? 1 : modulo;
    cipher_words = pristine_words;
    kc[0] = id;
    kc[1] = id >> 1;
    kc[2] = id << 1;
    if (level >= 1) keycode_pass(kc, m);
    if (level >= 2) keycode_pass(kc, m);
    if (level == 3) begin
      kc[1] <<= 1;
      kc[2] >>= 1;
      keycode_pass(kc, m);
    end
  endfunction

  // ------------------------------------------------------------------- sender
  // Drives one item at the falling edge, holds it until taken, then updates
  // the model. Valid stays high between back-to-back items.
  task automatic send_item(op_t o, bit [10:0] idx, bit [31:0] word, bit [31:0] lo,
                           bit [31:0] hi, bit [31:0] id, bit [1:0] lvl,
                           bit [1:0] modulo);
    int gap;
    gap = 0;
    if (!quiet_phase && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 9);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    op = o; table_index = idx; table_word = word;
    block_low = lo; block_high = hi;
    key_id = id; key_level = lvl; key_modulo = modulo;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    case (o)
      OP_LOAD: if (idx < TableWords) pristine_words[idx] = word;
      OP_KEY:  apply_key(id, lvl, modulo);
      default: pending_blocks.push_back(cipher_block('{lo: lo, hi: hi}, o == OP_DEC));
    endcase
    @(negedge clk);
  endtask

  task automatic send_block(op_t o, bit [31:0] lo, bit [31:0] hi);
    send_item(o, 11'($urandom), $urandom, lo, hi, $urandom, 2'($urandom), 2'($urandom));
  endtask

  task automatic send_key(bit [31:0] id, bit [1:0] lvl, bit [1:0] modulo);
    send_item(OP_KEY, 11'($urandom), $urandom, $urandom, $urandom, id, lvl, modulo);
  endtask

  task automatic drain_results();
    in_valid = 1'b0;
    while (pending_blocks.size() != 0) @(negedge clk);
  endtask

  // ------------------------------------------------------------ receive side
  // Random stall bursts on the output, none in the quiet phase
  always @(negedge clk) begin
    if (quiet_phase) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else if (out_stall) begin
      out_stall <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 8);
    end
  end

  // Each taken result is matched against the oldest prediction.
  always @(posedge clk) begin
    block_t exp_blk;
    if (!rst && out_valid && !out_stall) begin
      if (pending_blocks.size() == 0) begin
        $error("unexpected result out_low=%h out_high=%h", out_low, out_high);
        fail_count++;
      end else begin
        exp_blk = pending_blocks.pop_front();
        if (out_low !== exp_blk.lo) begin
          $error("out_low expected %h actual %h", exp_blk.lo, out_low);
          fail_count++;
        end
        if (out_high !== exp_blk.hi) begin
          $error("out_high expected %h actual %h", exp_blk.hi, out_high);
          fail_count++;
        end
      end
    end
  end

  // -------------------------------------------------------------------- tests
  // Fill the whole pristine table, extremes at both ends, plus dropped loads.
  task automatic test_table_fill();
    for (int i = 0; i < TableWords; i++) begin
      bit [31:0] w;
      w = (i == 0) ? 32'h0 : (i == TableWords - 1) ? 32'hFFFF_FFFF : $urandom;
      send_item(OP_LOAD, 11'(i), w, $urandom, $urandom, $urandom, 2'($urandom),
                2'($urandom));
    end
    send_item(OP_LOAD, 11'd1042, 32'hDEAD_BEEF, '0, '0, '0, '0, '0);
    send_item(OP_LOAD, 11'h7FF, 32'hFFFF_FFFF, '0, '0, '0, '0, '0);
  endtask

  // Every level and modulo, including modulo zero and plain copy at level zero.
  task automatic test_key_schedule();
    bit [31:0] ids [4] = '{32'h0, 32'hFFFF_FFFF, $urandom, $urandom};
    for (int lvl = 0; lvl < 4; lvl++) begin
      send_key(ids[lvl], 2'(lvl), 2'(lvl));
      send_block(OP_ENC, $urandom, $urandom);
      send_block(OP_DEC, $urandom, $urandom);
    end
  endtask

  task automatic test_block_extremes();
    send_block(OP_ENC, 32'h0, 32'h0);
    send_block(OP_ENC, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_block(OP_DEC, 32'h0, 32'hFFFF_FFFF);
    send_block(OP_DEC, 32'hFFFF_FFFF, 32'h0);
    // hold off until everything queued has come back
    drain_results();
    send_block(OP_ENC, 32'h8000_0001, 32'h7FFF_FFFE);
  endtask

  // Mostly blocks, some pristine rewrites (some out of range), rare key inits.
  task automatic test_random_traffic(int count);
    int pick;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 12)
        send_item(OP_LOAD, 11'($urandom_range(0, 2047)), $urandom, $urandom, $urandom,
                  $urandom, 2'($urandom), 2'($urandom));
      else if (pick < 14 && key_inits_left > 0) begin
        key_inits_left--;
        send_key($urandom, 2'($urandom_range(0, 1)), 2'($urandom));
      end else
        send_block(pick[0] ? OP_ENC : OP_DEC, $urandom, $urandom);
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_table_fill();
    test_key_schedule();
    test_block_extremes();
    test_random_traffic(640);
    quiet_phase = 1'b1;
    test_random_traffic(120);
    drain_results();
    repeat (100) @(posedge clk);
    if (fail_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  initial begin
    #20ms;
    $display("Regression FAIL");
    $finish;
  end

endmodule

[sim.f]
hdl/key1bf_pkg.sv
hdl/key1bf_front.sv
hdl/key1bf_queue.sv
hdl/key1bf_back.sv
hdl/key1_blowfish_cipher_core.sv
tb/sv/tb_key1_blowfish_cipher_core.sv
